// ===== rtl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants of the linear ADSR envelope generator: stage and
// operation codes, configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

    localparam int LEVEL_FRACTION_BITS_DEF = 24;
    localparam int DELAY_BITS_DEF          = 16;

    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK_STEP   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_STEP    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_STEP  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RETRIGGER     = 3'd4;

    localparam int STAGE_W = 3;
    localparam int OP_W    = 2;

    typedef enum logic [STAGE_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_GATE      = 2'd1,
        OP_TRIGGER   = 2'd2,
        OP_SET_LEVEL = 2'd3
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/adsr_envelope_generator_top.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_generator_top
// Linear ADSR envelope: every input beat (tick, gate, trigger or set level)
// updates the envelope state and returns one beat with level and stage.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel i_s_*: one operation per beat, kind in tuser, operands in
//   tdata. Master channel o_m_*: one result beat per input beat, in order.
//   Configuration: i_cfg_we / i_cfg_addr / i_cfg_data write a register at the
//   clock edge; write only while no beat is in flight.
// Path: an accepted input beat goes through the input register, then the
//   envelope state, which is the result register, before it shows on o_m_*.
// Throughput: one beat per cycle while not stalled; the whole update is a single
//   add or subtract, a compare and the stage decision between those two registers.
// Reset (synchronous, active low): level 0, stage idle, gate mode, gate
//   released, no delay pending, steps and sustain at 1.0, retrigger off.
// Stall: while i_m_tready is low the result holds, the input register keeps
//   one more beat and o_s_tready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator_top #(
    parameter int LEVEL_FRACTION_BITS = adsr_pkg::LEVEL_FRACTION_BITS_DEF,
    parameter int DELAY_BITS          = adsr_pkg::DELAY_BITS_DEF,
    localparam int LW    = LEVEL_FRACTION_BITS + 1,
    localparam int IN_W  = ((1 + DELAY_BITS + LW + 7) / 8) * 8,
    localparam int OUT_W = ((LW + adsr_pkg::STAGE_W + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // gate_on, gate_delay, new_level (low bit first)
    input  wire logic [IN_W-1:0]                 i_s_tdata,
    // operation
    input  wire logic [adsr_pkg::OP_W-1:0]       i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // level, stage (low bit first)
    output logic [OUT_W-1:0]                     o_m_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [adsr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [LW-1:0]                   i_cfg_data
);
    import adsr_pkg::*;

    localparam logic [LW-1:0] LEVEL_ONE  = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};
    localparam logic [LW-1:0] LEVEL_ZERO = '0;

    logic [LW-1:0]         r_attack_step;
    logic [LW-1:0]         r_decay_step;
    logic [LW-1:0]         r_release_step;
    logic [LW-1:0]         r_sustain;
    logic                  r_retrigger;

    logic                  r_in_valid;
    t_op                   r_in_op;
    logic                  r_in_gate_on;
    logic [DELAY_BITS-1:0] r_in_delay;
    logic [LW-1:0]         r_in_level;

    logic                  r_out_valid;
    logic [LW-1:0]         r_level;
    t_stage                r_stage;
    logic                  r_trig;
    logic                  r_gate;
    logic                  r_delay_act;
    logic [DELAY_BITS-1:0] r_delay_cnt;

    logic [LW-1:0]         n_level;
    t_stage                n_stage;
    logic                  n_trig;
    logic                  n_gate;
    logic                  n_delay_act;
    logic [DELAY_BITS-1:0] n_delay_cnt;

    logic                  w_adv;
    logic                  w_fire;
    t_stage                w_stage;
    logic                  w_gate;
    logic [LW:0]           w_sum;
    logic [LW-1:0]         w_dec;
    logic [LW-1:0]         w_rel;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_stage, r_level});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_step  <= LEVEL_ONE;
            r_decay_step   <= LEVEL_ONE;
            r_release_step <= LEVEL_ONE;
            r_sustain      <= LEVEL_ONE;
            r_retrigger    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ATTACK_STEP:   r_attack_step  <= i_cfg_data;
                CFG_DECAY_STEP:    r_decay_step   <= i_cfg_data;
                CFG_RELEASE_STEP:  r_release_step <= i_cfg_data;
                CFG_SUSTAIN_LEVEL: r_sustain <= (i_cfg_data > LEVEL_ONE) ? LEVEL_ONE
                                                                          : i_cfg_data;
                CFG_RETRIGGER:     r_retrigger    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op      <= t_op'(i_s_tuser);
            r_in_gate_on <= i_s_tdata[0];
            r_in_delay   <= i_s_tdata[DELAY_BITS:1];
            r_in_level   <= i_s_tdata[DELAY_BITS+LW:DELAY_BITS+1];
        end
    end

    // delayed start and the ramp arithmetic of a tick
    assign w_fire  = r_delay_act && (r_delay_cnt == '0);
    assign w_stage = w_fire ? ST_ATTACK : r_stage;
    assign w_gate  = (w_fire && r_trig) ? 1'b0 : r_gate;
    assign w_sum   = {1'b0, r_level} + {1'b0, r_attack_step};
    assign w_dec   = (r_level > r_decay_step) ? (r_level - r_decay_step) : LEVEL_ZERO;
    assign w_rel   = (r_level > r_release_step) ? (r_level - r_release_step) : LEVEL_ZERO;

    always_comb begin
        n_level     = r_level;
        n_stage     = r_stage;
        n_trig      = r_trig;
        n_gate      = r_gate;
        n_delay_act = r_delay_act;
        n_delay_cnt = r_delay_cnt;
        case (r_in_op)
            OP_TICK: begin
                n_stage = w_stage;
                n_gate  = w_gate;
                if (r_delay_act) begin
                    if (r_delay_cnt == '0) begin
                        n_delay_act = 1'b0;
                    end else begin
                        n_delay_cnt = r_delay_cnt - 1'b1;
                    end
                end
                case (w_stage)
                    ST_ATTACK: begin
                        if (w_sum >= {1'b0, LEVEL_ONE}) begin
                            n_level = LEVEL_ONE;
                            n_stage = ST_DECAY;
                        end else begin
                            n_level = w_sum[LW-1:0];
                            if (!w_gate && !r_trig) begin
                                n_stage = ST_RELEASE;
                            end
                        end
                    end
                    ST_DECAY: begin
                        if (w_dec <= r_sustain) begin
                            n_level = r_sustain;
                            n_stage = r_trig ? ST_RELEASE : ST_SUSTAIN;
                        end else begin
                            n_level = w_dec;
                            if (!w_gate && !r_trig) begin
                                n_stage = ST_RELEASE;
                            end
                        end
                    end
                    ST_SUSTAIN: begin
                        n_level = r_sustain;
                        if (!w_gate) begin
                            n_stage = ST_RELEASE;
                        end
                    end
                    ST_RELEASE: begin
                        n_level = w_rel;
                        if (w_rel == LEVEL_ZERO) begin
                            if (r_retrigger) begin
                                n_trig = 1'b1;
                                if (!w_gate) begin
                                    n_gate      = 1'b1;
                                    n_delay_act = 1'b1;
                                    n_delay_cnt = '0;
                                end
                            end else begin
                                n_stage = ST_IDLE;
                            end
                        end else if (w_gate) begin
                            n_stage = ST_ATTACK;
                        end
                    end
                    default: begin
                        n_level = LEVEL_ZERO;
                        n_stage = w_gate ? ST_ATTACK : ST_IDLE;
                    end
                endcase
            end
            OP_GATE, OP_TRIGGER: begin
                n_trig = (r_in_op == OP_TRIGGER);
                if (r_in_gate_on != r_gate) begin
                    n_gate      = r_in_gate_on;
                    n_delay_act = 1'b1;
                    n_delay_cnt = r_in_delay;
                end
            end
            default: begin
                n_level = (r_in_level > LEVEL_ONE) ? LEVEL_ONE : r_in_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= LEVEL_ZERO;
            r_stage     <= ST_IDLE;
            r_trig      <= 1'b0;
            r_gate      <= 1'b0;
            r_delay_act <= 1'b0;
            r_delay_cnt <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_level     <= n_level;
                r_stage     <= n_stage;
                r_trig      <= n_trig;
                r_gate      <= n_gate;
                r_delay_act <= n_delay_act;
                r_delay_cnt <= n_delay_cnt;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adsr_checker.sv =====
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks of the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_checker #(
    parameter int LEVEL_FRACTION_BITS = adsr_pkg::LEVEL_FRACTION_BITS_DEF,
    parameter int DELAY_BITS          = adsr_pkg::DELAY_BITS_DEF,
    localparam int LW    = LEVEL_FRACTION_BITS + 1,
    localparam int OUT_W = ((LW + adsr_pkg::STAGE_W + 7) / 8) * 8
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_tvalid,
    input wire logic             o_s_tready,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata
);
    localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};
    localparam int            DELAY_W   = DELAY_BITS;

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // level never exceeds 1.0
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[LW-1:0] <= LEVEL_ONE)
        else $error("level above 1.0 (delay width %0d)", DELAY_W);

    // no result beat straight out of reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result beat right after reset");

    // a new result follows from an accepted input beat
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result beat without an input beat");

endmodule

bind adsr_envelope_generator_top adsr_checker #(
    .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS),
    .DELAY_BITS         (DELAY_BITS)
) u_adsr_checker (.*);

`default_nettype wire
